// ===== hdl/sdar_pkg.sv =====
// shared types and constants for the stick to direction autorepeat core
// no dependencies
package sdar_pkg;

   localparam logic [31:0] MARK_IDLE = 32'd2147483647;

   localparam logic [14:0] TRIGGER_RESET  = 15'd16384;
   localparam logic [14:0] RELAX_RESET    = 15'd11469;
   localparam logic [15:0] DELAY_RESET    = 16'd200;
   localparam logic [15:0] INTERVAL_RESET = 16'd100;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELAX    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELAY    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERVAL = 2'd3;

   localparam logic [1:0] DIRECTION_LEFT  = 2'd0;
   localparam logic [1:0] DIRECTION_RIGHT = 2'd1;
   localparam logic [1:0] DIRECTION_UP    = 2'd2;
   localparam logic [1:0] DIRECTION_DOWN  = 2'd3;

   typedef enum logic [1:0] {
      DIR_IDLE = 2'd0,
      DIR_NEG  = 2'd1,
      DIR_POS  = 2'd2
   } axis_dir_type;

   typedef struct packed {
      logic [14:0] trigger_level;
      logic [14:0] relax_level;
      logic [15:0] repeat_delay_ms;
      logic [15:0] repeat_interval_ms;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] x_sample;
      logic signed [15:0] y_sample;
      logic [31:0]        now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0] direction;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic fire;
      logic positive;
   } axis_event_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } evq_push_type;

endpackage

// ===== hdl/sdar_axis.sv =====
// one stick axis: direction state, repeat flag, event time mark and event decision
// depends on sdar_pkg
module sdar_axis (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    update,
   input  logic signed [15:0]      sample,
   input  logic [31:0]             now_ms,
   input  sdar_pkg::cfg_type       cfg,
   output sdar_pkg::axis_event_type evt
);
   import sdar_pkg::*;

   axis_dir_type dir_ff, dir_in;
   logic         rep_ff, rep_in;
   logic [31:0]  mark_ff, mark_in;

   logic [15:0] mag;
   logic [31:0] elapsed;
   logic        active, release_hit, int_hit, del_hit, trig_hit, neg_hit, pos_hit;

   assign mag         = sample[15] ? (~sample + 16'd1) : sample;
   assign elapsed     = now_ms - mark_ff;
   assign active      = (dir_ff == DIR_NEG) || (dir_ff == DIR_POS);
   assign trig_hit    = mag > {1'b0, cfg.trigger_level};
   assign release_hit = active && (mag < {1'b0, cfg.relax_level});
   assign int_hit     = active && !release_hit && rep_ff
                        && (elapsed > {16'd0, cfg.repeat_interval_ms});
   assign del_hit     = active && !release_hit && !int_hit
                        && (elapsed > {16'd0, cfg.repeat_delay_ms});
   assign neg_hit     = !active && sample[15] && trig_hit;
   assign pos_hit     = !active && !sample[15] && trig_hit;

   always_comb begin
      dir_in  = dir_ff;
      rep_in  = rep_ff;
      mark_in = mark_ff;
      if (update) begin
         priority if (release_hit) begin
            dir_in  = DIR_IDLE;
            rep_in  = 1'b0;
            mark_in = MARK_IDLE;
         end else if (int_hit) begin
            mark_in = now_ms;
         end else if (del_hit) begin
            rep_in  = 1'b1;
            mark_in = now_ms;
         end else if (neg_hit) begin
            dir_in  = DIR_NEG;
            rep_in  = 1'b0;
            mark_in = now_ms;
         end else if (pos_hit) begin
            dir_in  = DIR_POS;
            rep_in  = 1'b0;
            mark_in = now_ms;
         end else begin
            // no event, state holds
            mark_in = mark_ff;
         end
      end
   end

   always_comb begin
      evt.fire     = int_hit || del_hit || neg_hit || pos_hit;
      evt.positive = active ? (dir_ff == DIR_POS) : pos_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff  <= DIR_IDLE;
         rep_ff  <= 1'b0;
         mark_ff <= MARK_IDLE;
      end else begin
         dir_ff  <= dir_in;
         rep_ff  <= rep_in;
         mark_ff <= mark_in;
      end
   end

endmodule

// ===== hdl/sdar_evq.sv =====
// four-entry event queue: takes up to two events a cycle, hands out one beat a cycle while rsp_stall is low
// depends on sdar_pkg
module sdar_evq (
   input  logic                   clock,
   input  logic                   reset,
   input  sdar_pkg::evq_push_type push,
   output logic                   room,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sdar_pkg::rsp_type      rsp_data
);
   import sdar_pkg::*;

   rsp_type     mem_ff [4];
   logic [1:0]  wr_ptr_ff, wr_ptr_in;
   logic [1:0]  rd_ptr_ff, rd_ptr_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        pop;
   logic [2:0]  cnt_after_pop;

   assign rsp_valid     = cnt_ff != 3'd0;
   assign rsp_data      = mem_ff[rd_ptr_ff];
   assign pop           = rsp_valid && !rsp_stall;
   assign cnt_after_pop = cnt_ff - {2'd0, pop};
   assign room          = cnt_after_pop <= 3'd2;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      cnt_in    = cnt_after_pop + {1'b0, push.count};
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + 2'd1] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         cnt_ff    <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== hdl/stick_to_direction_autorepeat_core.sv =====
// top level of the stick to direction autorepeat core
// depends on sdar_pkg, sdar_axis, sdar_evq
//
// Usage:
//   req channel: one beat carries an x/y stick sample and a millisecond
//   timestamp. rsp channel: each beat is one direction event (left, right,
//   up, down) with last marking the final event of that sample; a sample
//   gives zero, one or two beats, x before y. Samples with no event give
//   no beat at all.
//   csr port: write trigger_level, relax_level, repeat_delay_ms and
//   repeat_interval_ms by index while the core is idle; no read-back.
// Timing:
//   a sample is held in the input register, is evaluated against the axis
//   state once the queue has room and its events land in a four-entry
//   queue, from which the first beat is offered; a second beat of the same
//   sample is offered once the first has been taken.
//   A sample is taken every cycle while the queue can hold two more events;
//   with the rsp side always ready the sustained rate is set by the single
//   rsp beat per cycle, so samples that give two events slow the intake.
// Reset and stall:
//   reset clears both axes to idle, empties the queue and restores the
//   register defaults. When rsp_stall holds, the queue fills and req_stall
//   rises once the input register cannot be drained.
module stick_to_direction_autorepeat_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  sdar_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output sdar_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [sdar_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sdar_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sdar_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   logic           in_valid_ff, in_valid_in;
   req_type        in_ff;
   logic           room, accept, consume;
   axis_event_type x_evt, y_evt;
   rsp_type        x_rsp, y_rsp;
   evq_push_type   push;

   assign consume   = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TRIGGER:  cfg_in.trigger_level      = csr_wdata[14:0];
            CSR_RELAX:    cfg_in.relax_level        = csr_wdata[14:0];
            CSR_DELAY:    cfg_in.repeat_delay_ms    = csr_wdata;
            CSR_INTERVAL: cfg_in.repeat_interval_ms = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         cfg_ff      <= '{TRIGGER_RESET, RELAX_RESET, DELAY_RESET, INTERVAL_RESET};
      end else begin
         in_valid_ff <= in_valid_in;
         cfg_ff      <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
   end

   sdar_axis u_axis_x (
      .clock  (clock),
      .reset  (reset),
      .update (consume),
      .sample (in_ff.x_sample),
      .now_ms (in_ff.now_ms),
      .cfg    (cfg_ff),
      .evt    (x_evt)
   );

   sdar_axis u_axis_y (
      .clock  (clock),
      .reset  (reset),
      .update (consume),
      .sample (in_ff.y_sample),
      .now_ms (in_ff.now_ms),
      .cfg    (cfg_ff),
      .evt    (y_evt)
   );

   always_comb begin
      x_rsp.direction = x_evt.positive ? DIRECTION_RIGHT : DIRECTION_LEFT;
      x_rsp.last      = !y_evt.fire;
      y_rsp.direction = y_evt.positive ? DIRECTION_DOWN : DIRECTION_UP;
      y_rsp.last      = 1'b1;
      push.count      = 2'd0;
      push.first      = x_rsp;
      push.second     = y_rsp;
      if (consume) begin
         push.count = {1'b0, x_evt.fire} + {1'b0, y_evt.fire};
         if (!x_evt.fire) begin
            push.first = y_rsp;
         end
      end
   end

   sdar_evq u_evq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/sdar_checker.sv =====
// port-level checks for the stick to direction autorepeat core, bound to the top level
// depends on sdar_pkg and stick_to_direction_autorepeat_core
module sdar_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input sdar_pkg::req_type                req_data,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input sdar_pkg::rsp_type                rsp_data
);
   import sdar_pkg::*;

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // a stalled request beat is held by the sender
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("req beat changed while stalled");

   // reset leaves nothing to deliver
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp beat right after reset");

   // with nothing queued the core always takes a sample
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req stalled with empty queue");

   // the second event of a sample is queued together with the first
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=> rsp_valid)
      else $error("missing final beat of a sample");

endmodule

bind stick_to_direction_autorepeat_core sdar_checker u_sdar_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/testbench.sv =====
// testbench for stick_to_direction_autorepeat_core: directed and random stick samples
// with random stalls; events are checked against an in-bench axis predictor
// depends on sdar_pkg and the core rtl
module testbench;
   import sdar_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_TICKS = 8;
   localparam int PRINT_CAP    = 40;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_TRIGGER;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // predictor state
   cfg_type      cfg_model;
   axis_dir_type axis_dir [2];
   logic         axis_rep [2];
   logic [31:0]  axis_mark [2];
   rsp_type      pending_events [$];

   int          error_count = 0;
   int          cycle_count = 0;
   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;
   bit          hold_request = 1'b0;
   int          hold_cycles = 0;
   int          stick_aim [2] = '{0, 0};
   logic [31:0] stick_ms = '0;

   stick_to_direction_autorepeat_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_CAP)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // one axis: returns 1 when it emits, positive tells the side
   function automatic logic axis_step(input int a, input logic signed [15:0] s,
                                      input logic [31:0] now, output logic positive);
      int          value;
      int          mag;
      int          trig;
      logic [31:0] elapsed;
      value    = int'(s);
      mag      = (value < 0) ? -value : value;
      trig     = int'(cfg_model.trigger_level);
      elapsed  = now - axis_mark[a];
      positive = (axis_dir[a] == DIR_POS);
      if (axis_dir[a] == DIR_NEG || axis_dir[a] == DIR_POS) begin
         if (mag < int'(cfg_model.relax_level)) begin
            axis_dir[a]  = DIR_IDLE;
            axis_rep[a]  = 1'b0;
            axis_mark[a] = MARK_IDLE;
            return 1'b0;
         end
         if (axis_rep[a] && elapsed > {16'd0, cfg_model.repeat_interval_ms}) begin
            axis_mark[a] = now;
            return 1'b1;
         end
         if (elapsed > {16'd0, cfg_model.repeat_delay_ms}) begin
            axis_rep[a]  = 1'b1;
            axis_mark[a] = now;
            return 1'b1;
         end
         return 1'b0;
      end
      if (value < -trig || value > trig) begin
         positive     = (value > trig);
         axis_dir[a]  = positive ? DIR_POS : DIR_NEG;
         axis_rep[a]  = 1'b0;
         axis_mark[a] = now;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic predict_events(input req_type r);
      logic    x_pos, y_pos, x_fire, y_fire;
      rsp_type ev;
      x_fire = axis_step(0, r.x_sample, r.now_ms, x_pos);
      y_fire = axis_step(1, r.y_sample, r.now_ms, y_pos);
      if (x_fire) begin
         ev.direction = x_pos ? DIRECTION_RIGHT : DIRECTION_LEFT;
         ev.last      = !y_fire;
         pending_events.push_back(ev);
      end
      if (y_fire) begin
         ev.direction = y_pos ? DIRECTION_DOWN : DIRECTION_UP;
         ev.last      = 1'b1;
         pending_events.push_back(ev);
      end
   endtask

   task automatic send_sample(input logic signed [15:0] xs, input logic signed [15:0] ys,
                              input logic [31:0] now);
      req_type r;
      r.x_sample = xs;
      r.y_sample = ys;
      r.now_ms   = now;
      if (req_idle_on) begin
         while ($urandom_range(99) < 12) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      predict_events(r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic program_regs(input logic [15:0] trig, input logic [15:0] relax,
                               input logic [15:0] delay, input logic [15:0] interval);
      logic [CSR_INDEX_W-1:0] idx [4];
      logic [15:0]            vals [4];
      wait_drained();
      idx  = '{CSR_TRIGGER, CSR_RELAX, CSR_DELAY, CSR_INTERVAL};
      vals = '{trig, relax, delay, interval};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         case (idx[i])
            CSR_TRIGGER:  cfg_model.trigger_level      = vals[i][14:0];
            CSR_RELAX:    cfg_model.relax_level        = vals[i][14:0];
            CSR_DELAY:    cfg_model.repeat_delay_ms    = vals[i];
            CSR_INTERVAL: cfg_model.repeat_interval_ms = vals[i];
            default: ;
         endcase
      end
      csr_we <= 1'b0;
   endtask

   // held stick positions with random content, plus noise and threshold probes
   function automatic logic signed [15:0] random_axis_value(input int a);
      int   trig, relax, m, lo, r;
      logic negative;
      trig  = int'(cfg_model.trigger_level);
      relax = int'(cfg_model.relax_level);
      if ($urandom_range(99) < 15) stick_aim[a] = $urandom_range(2);
      r        = $urandom_range(99);
      negative = 1'($urandom_range(1));
      if (r < 10) return 16'($urandom_range(65535));
      if (r < 22) begin
         m = ((r < 16) ? trig : relax) + $urandom_range(2) - 1;
         if (m < 0) m = 0;
      end else if (stick_aim[a] == 0) begin
         m = (relax == 0) ? 0 : $urandom_range(relax - 1);
      end else begin
         lo = (trig + 1 > relax) ? trig + 1 : relax;
         if (lo > 32767) lo = 32767;
         m        = $urandom_range(32767, lo);
         negative = (stick_aim[a] == 1);
         if (negative && $urandom_range(9) == 0) m = 32768;
      end
      if (m > 32767 && !negative) m = 32767;
      return negative ? 16'(-m) : 16'(m);
   endfunction

   always @(posedge clock) begin : event_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            report_mismatch($sformatf("unexpected event direction %0d last %0d",
                                      rsp_data.direction, rsp_data.last));
         end else begin
            want = pending_events.pop_front();
            if (rsp_data.direction !== want.direction)
               report_mismatch($sformatf("direction got %0d want %0d",
                                         rsp_data.direction, want.direction));
            if (rsp_data.last !== want.last)
               report_mismatch($sformatf("last got %0d want %0d",
                                         rsp_data.last, want.last));
         end
      end
   end

   always begin : rsp_pacing
      @(posedge clock);
      if (hold_request) begin
         hold_request = 1'b0;
         rsp_stall <= 1'b1;
         repeat (hold_cycles) @(posedge clock);
      end else begin
         rsp_stall <= rsp_idle_on && ($urandom_range(99) < 12);
      end
   end

   task automatic test_reset_levels();
      send_sample(16'sd0, 16'sd0, 32'd0);
      send_sample(16'sd16384, -16'sd16384, 32'hFFFF_FFFF);
      send_sample(16'sd16385, 16'sd0, 32'd1000);
      send_sample(16'sd11469, -16'sd16385, 32'd1200);
      send_sample(16'sd11469, -16'sd11469, 32'd1201);
      send_sample(16'sd32767, -16'sd32768, 32'd1301);
      send_sample(16'sd32767, -16'sd32768, 32'd1302);
      send_sample(16'sd11468, -16'sd32768, 32'd1500);
      send_sample(-16'sd32768, 16'sd0, 32'd1501);
      send_sample(16'sd0, 16'sd32767, 32'hFFFF_FF80);
      send_sample(-16'sd32768, 16'sd32767, 32'h0000_0049);
      send_sample(16'sd0, 16'sd0, 32'h0000_004A);
   endtask

   // zero trigger fires on any nonzero sample, zero relax never releases
   task automatic test_zero_levels();
      program_regs(16'd0, 16'd0, 16'd0, 16'd0);
      send_sample(16'sd1, 16'sd0, 32'd10);
      send_sample(16'sd0, -16'sd1, 32'd10);
      send_sample(16'sd0, 16'sd0, 32'd11);
      send_sample(16'sd0, 16'sd0, 32'd11);
      send_sample(-16'sd32768, 16'sd32767, 32'd12);
   endtask

   task automatic test_full_scale_levels();
      program_regs(16'd32767, 16'd32767, 16'd65535, 16'd65535);
      send_sample(16'sd32767, -16'sd32767, 32'd100);
      send_sample(-16'sd32768, -16'sd32768, 32'd100);
      send_sample(-16'sd32767, -16'sd32768, 32'd65635);
      send_sample(-16'sd32768, -16'sd32767, 32'd65636);
      send_sample(-16'sd32766, 16'sd0, 32'd65637);
   endtask

   // repeats follow the delay when the interval is longer
   task automatic test_interval_over_delay();
      program_regs({1'b0, TRIGGER_RESET}, {1'b0, RELAX_RESET}, 16'd50, 16'd300);
      send_sample(-16'sd20000, 16'sd20000, 32'd5000);
      send_sample(-16'sd20000, 16'sd20000, 32'd5051);
      send_sample(-16'sd20000, 16'sd20000, 32'd5101);
      send_sample(-16'sd20000, 16'sd20000, 32'd5102);
   endtask

   // every sample repeats on both axes while the receiver holds off
   task automatic test_backpressure();
      program_regs({1'b0, TRIGGER_RESET}, {1'b0, RELAX_RESET}, 16'd0, 16'd0);
      req_idle_on  = 1'b0;
      rsp_idle_on  = 1'b0;
      hold_cycles  = 80;
      hold_request = 1'b1;
      for (int i = 0; i < 30; i++)
         send_sample(16'sd30000, -16'sd30000, 32'd7000 + i);
      wait_drained();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      logic [15:0] trig, relax, delay, interval, span_pick;
      int          span, r, a;
      for (int p = 0; p < 6; p++) begin
         if (p == 0) begin
            trig     = {1'b0, TRIGGER_RESET};
            relax    = {1'b0, RELAX_RESET};
            delay    = DELAY_RESET;
            interval = INTERVAL_RESET;
         end else begin
            trig     = 16'($urandom_range(32767));
            relax    = ($urandom_range(3) != 0) ? 16'($urandom_range(trig)) :
                                                  16'($urandom_range(32767));
            delay    = ($urandom_range(4) == 0) ? 16'($urandom_range(65535)) :
                                                  16'($urandom_range(300));
            interval = ($urandom_range(4) == 0) ? 16'($urandom_range(65535)) :
                                                  16'($urandom_range(300));
         end
         program_regs(trig, relax, delay, interval);
         req_idle_on = (p != 3);
         rsp_idle_on = (p != 3);
         span = int'((delay > interval) ? delay : interval);
         if (span > 600) span = 600;
         for (int i = 0; i < 115; i++) begin
            if (p == 4 && i == 20) begin
               hold_cycles  = 50;
               hold_request = 1'b1;
            end
            if (p == 2 && i == 60) wait_drained();
            r = $urandom_range(99);
            if (r < 5) begin
               stick_ms = $urandom();
            end else if (r < 20) begin
               a         = $urandom_range(1);
               span_pick = $urandom_range(1) ? delay : interval;
               stick_ms  = axis_mark[a] + {16'd0, span_pick} + $urandom_range(1);
            end else begin
               stick_ms = stick_ms + $urandom_range(span / 2 + 2);
            end
            send_sample(random_axis_value(0), random_axis_value(1), stick_ms);
         end
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      cfg_model.trigger_level      = TRIGGER_RESET;
      cfg_model.relax_level        = RELAX_RESET;
      cfg_model.repeat_delay_ms    = DELAY_RESET;
      cfg_model.repeat_interval_ms = INTERVAL_RESET;
      for (int a = 0; a < 2; a++) begin
         axis_dir[a]  = DIR_IDLE;
         axis_rep[a]  = 1'b0;
         axis_mark[a] = MARK_IDLE;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_levels();
      test_zero_levels();
      test_full_scale_levels();
      test_interval_over_delay();
      test_backpressure();
      test_random_traffic();
      wait_drained();
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
